>>> src/lffm_pkg.sv
`default_nettype none
package lffm_pkg;

    // field widths
    localparam int MEASURE_W = 23;
    localparam int TIME_W    = 16;
    localparam int RUN_W     = 4;
    localparam int CFG_IDX_W = 3;

    // scaling and saturation
    localparam int                 MEASURE_SCALE = 100;
    localparam logic [MEASURE_W-1:0] MEASURE_MAX = '1;
    localparam logic [RUN_W-1:0]   RUN_MAX       = '1;

    // defaults
    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam logic [MEASURE_W-1:0] RST_WINDOW_LOW    = MEASURE_W'(0);
    localparam logic [MEASURE_W-1:0] RST_WINDOW_HIGH   = MEASURE_W'(6553500);
    localparam logic [TIME_W-1:0]    RST_SAMPLE_PERIOD = TIME_W'(1000);
    localparam logic [TIME_W-1:0]    RST_BLINK_ON      = TIME_W'(3000);
    localparam logic [TIME_W-1:0]    RST_BLINK_CYCLE   = TIME_W'(6000);
    localparam logic [RUN_W-1:0]     RST_CONFIRM_RUNS  = RUN_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW    = 3'd0,
        CFG_WINDOW_HIGH   = 3'd1,
        CFG_SAMPLE_PERIOD = 3'd2,
        CFG_BLINK_ON      = 3'd3,
        CFG_BLINK_CYCLE   = 3'd4,
        CFG_CONFIRM_RUNS  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [MEASURE_W-1:0] window_low;
        logic [MEASURE_W-1:0] window_high;
        logic [TIME_W-1:0]    sample_period;
        logic [TIME_W-1:0]    blink_on_time;
        logic [TIME_W-1:0]    blink_cycle_time;
        logic [RUN_W-1:0]     confirm_runs;
    } cfg_t;

    typedef struct packed {
        logic req_type;
        logic enable;
    } item_t;

    typedef struct packed {
        logic                 lamp_on;
        logic                 fault;
        logic                 measure_valid;
        logic [MEASURE_W-1:0] measure;
    } result_t;

endpackage
`default_nettype wire

>>> src/lffm_in_stage.sv
`default_nettype none
module lffm_in_stage
    import lffm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

>>> src/lffm_core.sv
`default_nettype none
module lffm_core
    import lffm_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    // product width, never narrower than the measure plus one
    localparam int PROD_W = (COUNT_WIDTH + 7 > MEASURE_W + 1) ? COUNT_WIDTH + 7 : MEASURE_W + 1;

    logic [COUNT_WIDTH-1:0] pulse_count_reg, pulse_count_next;
    logic [TIME_W-1:0]      window_elapsed_reg, window_elapsed_next;
    logic [TIME_W-1:0]      blink_elapsed_reg, blink_elapsed_next;
    logic [RUN_W-1:0]       good_run_reg, good_run_next;
    logic [RUN_W-1:0]       bad_run_reg, bad_run_next;
    logic                   fault_flag_reg, fault_flag_next;
    logic                   lamp_state_reg, lamp_state_next;

    logic [PROD_W-1:0]      product;
    logic [MEASURE_W-1:0]   measure_sat;
    logic                   in_window;
    logic [RUN_W-1:0]       good_inc;
    logic [RUN_W-1:0]       bad_inc;
    logic                   meas_valid;
    logic [MEASURE_W-1:0]   meas_out;

    // scaled count, saturating
    assign product     = PROD_W'(pulse_count_reg) * PROD_W'(MEASURE_SCALE);
    assign measure_sat = (product > PROD_W'(MEASURE_MAX)) ? MEASURE_MAX
                                                          : product[MEASURE_W-1:0];
    assign in_window   = (measure_sat >= cfg.window_low) && (measure_sat <= cfg.window_high);
    assign good_inc    = (good_run_reg != RUN_MAX) ? good_run_reg + RUN_W'(1) : good_run_reg;
    assign bad_inc     = (bad_run_reg != RUN_MAX) ? bad_run_reg + RUN_W'(1) : bad_run_reg;

    always_comb
    begin
        pulse_count_next    = pulse_count_reg;
        window_elapsed_next = window_elapsed_reg;
        blink_elapsed_next  = blink_elapsed_reg;
        good_run_next       = good_run_reg;
        bad_run_next        = bad_run_reg;
        fault_flag_next     = fault_flag_reg;
        lamp_state_next     = lamp_state_reg;
        meas_valid          = 1'b0;
        meas_out            = '0;
        if (step)
        begin
            if (!item.req_type)
            begin
                if (blink_elapsed_reg != '1)
                begin
                    blink_elapsed_next = blink_elapsed_reg + TIME_W'(1);
                end
                if (item.enable)
                begin
                    if (fault_flag_reg)
                    begin
                        if (blink_elapsed_reg < cfg.blink_on_time)
                        begin
                            lamp_state_next = 1'b1;
                        end
                        else if (blink_elapsed_reg < cfg.blink_cycle_time)
                        begin
                            lamp_state_next = 1'b0;
                        end
                        else
                        begin
                            blink_elapsed_next = '0;
                        end
                    end
                    else
                    begin
                        lamp_state_next = 1'b1;
                    end
                    if (window_elapsed_reg != '1)
                    begin
                        window_elapsed_next = window_elapsed_reg + TIME_W'(1);
                    end
                    if (lamp_state_next && (window_elapsed_next >= cfg.sample_period))
                    begin
                        meas_valid = 1'b1;
                        meas_out   = measure_sat;
                        if (in_window)
                        begin
                            bad_run_next = '0;
                            if (good_inc >= cfg.confirm_runs)
                            begin
                                good_run_next   = '0;
                                fault_flag_next = 1'b0;
                            end
                            else
                            begin
                                good_run_next = good_inc;
                            end
                        end
                        else
                        begin
                            good_run_next = '0;
                            if (bad_inc >= cfg.confirm_runs)
                            begin
                                bad_run_next    = '0;
                                fault_flag_next = 1'b1;
                            end
                            else
                            begin
                                bad_run_next = bad_inc;
                            end
                        end
                        pulse_count_next    = '0;
                        window_elapsed_next = '0;
                    end
                end
            end
            else if (item.enable && (pulse_count_reg != '1))
            begin
                pulse_count_next = pulse_count_reg + COUNT_WIDTH'(1);
            end
            if (!item.enable)
            begin
                lamp_state_next     = 1'b0;
                pulse_count_next    = '0;
                window_elapsed_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg    <= '0;
            window_elapsed_reg <= '0;
            blink_elapsed_reg  <= '0;
            good_run_reg       <= '0;
            bad_run_reg        <= '0;
            fault_flag_reg     <= 1'b0;
            lamp_state_reg     <= 1'b0;
        end
        else
        begin
            pulse_count_reg    <= pulse_count_next;
            window_elapsed_reg <= window_elapsed_next;
            blink_elapsed_reg  <= blink_elapsed_next;
            good_run_reg       <= good_run_next;
            bad_run_reg        <= bad_run_next;
            fault_flag_reg     <= fault_flag_next;
            lamp_state_reg     <= lamp_state_next;
        end
    end

    assign result.lamp_on       = lamp_state_next;
    assign result.fault         = fault_flag_next;
    assign result.measure_valid = meas_valid;
    assign result.measure       = meas_out;

    a_fault_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(fault_flag_reg))
        else $error("fault flag moved without an item");

    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((good_run_reg != '0) && (bad_run_reg != '0)))
        else $error("good and bad runs both non-zero");

    a_disabled_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.enable) |=>
            (!lamp_state_reg && (pulse_count_reg == '0) && (window_elapsed_reg == '0)))
        else $error("disabled item did not clear lamp and counters");

endmodule
`default_nettype wire

>>> src/lffm_out_stage.sv
`default_nettype none
module lffm_out_stage
    import lffm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    output logic         out_free,
    output logic         m_axis_tvalid,
    input  wire logic    m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // lamp_on, fault, measure[22:0], zero pad
    output logic         m_axis_tuser    // measure_valid
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, result_reg.measure, result_reg.fault, result_reg.lamp_on};
    assign m_axis_tuser  = result_reg.measure_valid;

endmodule
`default_nettype wire

>>> src/lamp_frequency_fault_monitor.sv
// lamp feedback frequency fault monitor and lamp driver
// an item passes the input register, then the result register, from which its result is offered
// throughput: one item per cycle, sustained while the result side takes one per cycle
// reset (rst_n low, asynchronous): counters, fault and lamp cleared, registers to defaults
`default_nettype none
module lamp_frequency_fault_monitor
    import lffm_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH   // pulse counter width, 8 to 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // item stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // enable, zero pad
    input  wire logic                 s_axis_tuser,   // req_type: 0 tick, 1 feedback pulse
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [31:0]               m_axis_tdata,   // lamp_on, fault, measure[22:0], zero pad
    output logic                      m_axis_tuser,   // measure_valid
    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MEASURE_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    advance;
    result_t result;

    // register writes always taken; user must write only while block is quiet, not enforced
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW_LOW:    cfg_next.window_low       = cfg_data;
                CFG_WINDOW_HIGH:   cfg_next.window_high      = cfg_data;
                CFG_SAMPLE_PERIOD: cfg_next.sample_period    = cfg_data[TIME_W-1:0];
                CFG_BLINK_ON:      cfg_next.blink_on_time    = cfg_data[TIME_W-1:0];
                CFG_BLINK_CYCLE:   cfg_next.blink_cycle_time = cfg_data[TIME_W-1:0];
                CFG_CONFIRM_RUNS:  cfg_next.confirm_runs     = cfg_data[RUN_W-1:0];
                default:           cfg_next = cfg_reg;   // unmapped index, write ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low       <= RST_WINDOW_LOW;
            cfg_reg.window_high      <= RST_WINDOW_HIGH;
            cfg_reg.sample_period    <= RST_SAMPLE_PERIOD;
            cfg_reg.blink_on_time    <= RST_BLINK_ON;
            cfg_reg.blink_cycle_time <= RST_BLINK_CYCLE;
            cfg_reg.confirm_runs     <= RST_CONFIRM_RUNS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item.req_type = s_axis_tuser;
    assign in_item.enable   = s_axis_tdata[0];

    // an item moves through the core when its result register can take the result
    assign advance = item_valid && out_free;

    lffm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // monitor state lives here; updated once per item that advances
    lffm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    lffm_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // no measurement means a zero measure field
    a_measure_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[24:2] == '0))
        else $error("measure non-zero without a measurement");

    // a measurement is only ever reported with the lamp on
    a_measure_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[0])
        else $error("measurement reported with lamp off");

    // an item held in the input register with a free result side must move
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("item not advanced into free result register");

endmodule
`default_nettype wire

>>> tb/sv/lamp_frequency_fault_monitor_tb.sv
`default_nettype none
module lamp_frequency_fault_monitor_tb;
    import lffm_pkg::*;

    // item kinds carried on s_axis_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_PULSE = 1'b1;

    // length of the deliberate result-side hold-off, in cycles
    localparam int HOLD_LEN = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // item stream towards the block
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;    // enable, zero pad
    logic                 s_axis_tuser  = 1'b0;  // req_type
    // result stream from the block
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;          // lamp_on, fault, measure[22:0], zero pad
    logic                 m_axis_tuser;          // measure_valid
    // register write channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MEASURE_W-1:0] cfg_data  = '0;

    lamp_frequency_fault_monitor #(
        .COUNT_WIDTH (DEFAULT_COUNT_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // items waiting to be offered, and results owed by the block in order
    item_t   lamp_events_pending[$];
    result_t lamp_results_due[$];

    // idling knobs, set per phase by the stimulus process
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    // a toggle here asks the receiver for the long hold-off, counted down from HOLD_LEN
    logic hold_trigger  = 1'b0;
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;

    // bookkeeping
    int mismatch_count = 0;
    int items_accepted = 0;
    int measure_count  = 0;
    int fault_rises    = 0;
    int reg_writes     = 0;

    // shadow of the register file, starting at the reset defaults
    cfg_t lamp_regs = '{
        window_low       : RST_WINDOW_LOW,
        window_high      : RST_WINDOW_HIGH,
        sample_period    : RST_SAMPLE_PERIOD,
        blink_on_time    : RST_BLINK_ON,
        blink_cycle_time : RST_BLINK_CYCLE,
        confirm_runs     : RST_CONFIRM_RUNS
    };

    // shadow of the monitor state, all clear after reset
    logic [DEFAULT_COUNT_WIDTH-1:0] pulse_count    = '0;
    logic [TIME_W-1:0]              window_elapsed = '0;
    logic [TIME_W-1:0]              blink_elapsed  = '0;
    logic [RUN_W-1:0]               good_run       = '0;
    logic [RUN_W-1:0]               bad_run        = '0;
    logic                           fault_flag     = 1'b0;
    logic                           lamp_state     = 1'b0;

    // free-running clock, 10 time units per period
    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the block wedges
    initial
    begin
        #3000000;
        $display("lamp_frequency_fault_monitor_tb: done, errors");
        $finish;
    end

    // scaled pulse measurement and the run counters that confirm or clear a fault
    function automatic void score_window(ref result_t r);
        logic [31:0] scaled;
        scaled = 32'(pulse_count) * 32'(MEASURE_SCALE);
        if (scaled > 32'(MEASURE_MAX))
            scaled = 32'(MEASURE_MAX);
        r.measure       = scaled[MEASURE_W-1:0];
        r.measure_valid = 1'b1;
        measure_count++;
        if (scaled >= 32'(lamp_regs.window_low) && scaled <= 32'(lamp_regs.window_high))
        begin
            if (good_run != RUN_MAX)
                good_run++;
            bad_run = '0;
            if (good_run >= lamp_regs.confirm_runs)
            begin
                good_run   = '0;
                fault_flag = 1'b0;
            end
        end
        else
        begin
            good_run = '0;
            if (bad_run != RUN_MAX)
                bad_run++;
            if (bad_run >= lamp_regs.confirm_runs)
            begin
                bad_run = '0;
                if (!fault_flag)
                    fault_rises++;
                fault_flag = 1'b1;
            end
        end
        pulse_count    = '0;
        window_elapsed = '0;
    endfunction

    // advance the shadow state by one item and return the result it owes
    function automatic result_t predict_lamp_result(logic req_type, logic enable);
        result_t           r;
        logic [TIME_W-1:0] blink_was;
        r = '0;
        if (req_type == REQ_TICK)
        begin
            blink_was = blink_elapsed;
            if (blink_elapsed != '1)
                blink_elapsed++;
            if (enable)
            begin
                // fault blink: on phase, off phase, then the cycle restarts with
                // the lamp left as it was
                if (fault_flag)
                begin
                    if (blink_was < lamp_regs.blink_on_time)
                        lamp_state = 1'b1;
                    else if (blink_was < lamp_regs.blink_cycle_time)
                        lamp_state = 1'b0;
                    else
                        blink_elapsed = '0;
                end
                else
                    lamp_state = 1'b1;
                if (window_elapsed != '1)
                    window_elapsed++;
                if (lamp_state && window_elapsed >= lamp_regs.sample_period)
                    score_window(r);
            end
        end
        else if (enable && pulse_count != '1)
            pulse_count++;

        // disabled: lamp dark, pulse and window counters held at zero, run counters and fault kept
        if (!enable)
        begin
            lamp_state     = 1'b0;
            pulse_count    = '0;
            window_elapsed = '0;
        end

        r.lamp_on = lamp_state;
        r.fault   = fault_flag;
        return r;
    endfunction

    // item driver: offers queued items, predicting each one as its transfer completes
    always @(posedge clk)
    begin : drive_items
        item_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lamp_results_due.push_back(predict_lamp_result(s_axis_tuser, s_axis_tdata[0]));
                items_accepted++;
            end
            // the slot is free when nothing is offered or the offer just went through
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (lamp_events_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = lamp_events_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.req_type;
                    s_axis_tdata  <= {7'b0, nxt.enable};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result-side ready: random stalls, or a long hold-off when asked for
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen     <= hold_trigger;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // result monitor: each result transfer against the oldest owed result
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (lamp_results_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = lamp_results_due.pop_front();
                check_field("lamp_on", want.lamp_on, m_axis_tdata[0]);
                check_field("fault", want.fault, m_axis_tdata[1]);
                check_field("measure_valid", want.measure_valid, m_axis_tuser);
                check_field("measure", want.measure, m_axis_tdata[MEASURE_W+1:2]);
            end
        end
    end

    // one register transfer; the caller starts at a rising edge and lowers cfg_valid after
    // the last write of a batch
    task automatic write_reg(cfg_index_t idx, logic [MEASURE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_WINDOW_LOW:    lamp_regs.window_low       = value;
            CFG_WINDOW_HIGH:   lamp_regs.window_high      = value;
            CFG_SAMPLE_PERIOD: lamp_regs.sample_period    = value[TIME_W-1:0];
            CFG_BLINK_ON:      lamp_regs.blink_on_time    = value[TIME_W-1:0];
            CFG_BLINK_CYCLE:   lamp_regs.blink_cycle_time = value[TIME_W-1:0];
            CFG_CONFIRM_RUNS:  lamp_regs.confirm_runs     = value[RUN_W-1:0];
            default: ;
        endcase
    endtask

    // full register set; unused upper data bits carry random junk, which must be ignored
    task automatic load_regs(int lo, int hi, int period, int on_time, int cycle_time,
                             int confirm);
        @(posedge clk);
        write_reg(CFG_WINDOW_LOW, MEASURE_W'(lo));
        write_reg(CFG_WINDOW_HIGH, MEASURE_W'(hi));
        write_reg(CFG_SAMPLE_PERIOD, {7'($urandom), 16'(period)});
        write_reg(CFG_BLINK_ON, {7'($urandom), 16'(on_time)});
        write_reg(CFG_BLINK_CYCLE, {7'($urandom), 16'(cycle_time)});
        write_reg(CFG_CONFIRM_RUNS, {19'($urandom), 4'(confirm)});
        cfg_valid <= 1'b0;
    endtask

    // waits at falling edges until every item is through and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (lamp_events_pending.size() != 0 || s_axis_tvalid ||
               lamp_results_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_item(logic req_type, logic enable);
        item_t it;
        it.req_type = req_type;
        it.enable   = enable;
        lamp_events_pending.push_back(it);
    endtask

    // mostly sample windows (ticks capped at twelve), a burst of pulses spread among the ticks,
    // with about one step in ten a single random noise item that disables the lamp two times in five
    task automatic queue_traffic(int n, int period, int centre);
        int made;
        int pulses;
        int ticks;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(99) < 10)
            begin
                queue_item(1'($urandom_range(1)), ($urandom_range(99) < 60));
                made++;
            end
            else
            begin
                pulses = $urandom_range(2 * centre);
                if (period == 0)
                    ticks = 1;
                else if (period > 12)
                    ticks = $urandom_range(12, 1);
                else
                    ticks = period;
                while (pulses + ticks > 0)
                begin
                    if (pulses > 0 && (ticks == 0 || $urandom_range(pulses + ticks - 1) < pulses))
                    begin
                        queue_item(REQ_PULSE, 1'b1);
                        pulses--;
                    end
                    else
                    begin
                        queue_item(REQ_TICK, 1'b1);
                        ticks--;
                    end
                    made++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset defaults: disabled items, a pulse counted, the lamp lit by a tick
        queue_item(REQ_TICK, 1'b0);
        queue_item(REQ_PULSE, 1'b0);
        queue_item(REQ_PULSE, 1'b1);
        queue_item(REQ_TICK, 1'b1);
        queue_item(REQ_PULSE, 1'b1);
        queue_item(REQ_TICK, 1'b0);
        wait_drained();

        // short windows: one good measurement, then two empty ones raise the fault,
        // then blink ticks and disabled items
        load_regs(300, 500, 2, 2, 4, 2);
        @(negedge clk);
        repeat (4) queue_item(REQ_PULSE, 1'b1);
        repeat (2) queue_item(REQ_TICK, 1'b1);
        repeat (4) queue_item(REQ_TICK, 1'b1);
        repeat (3) queue_item(REQ_TICK, 1'b1);
        queue_item(REQ_PULSE, 1'b0);
        queue_item(REQ_TICK, 1'b0);
        wait_drained();

        // no idling, ordinary window
        load_regs(400, 900, 3, 3, 7, 3);
        @(negedge clk);
        queue_traffic(240, 3, 6);
        wait_drained();

        // sender idle most of the time; zero-width window at zero, a measurement due at every lit tick
        send_idle_pct = 76;
        load_regs(0, 0, 1, 1, 2, 1);
        @(negedge clk);
        queue_traffic(240, 1, 1);
        wait_drained();

        // receiver stalling, with one long hold-off so the block backs up its input;
        // zero period, zero confirm and zero blink times
        send_idle_pct = 0;
        stall_pct     = 76;
        load_regs(200, int'(MEASURE_MAX), 0, 0, 0, 0);
        @(negedge clk);
        queue_traffic(240, 0, 2);
        hold_trigger = ~hold_trigger;
        wait_drained();

        // both sides idling; longest confirm run and longest blink times
        send_idle_pct = 20;
        stall_pct     = 20;
        load_regs(500, 1500, 5, 65535, 65535, 15);
        @(negedge clk);
        queue_traffic(240, 5, 7);
        wait_drained();

        // window out of reach so the fault latches; blink on longer than the cycle;
        // the sender pauses half way until every result is back
        send_idle_pct = 0;
        stall_pct     = 0;
        load_regs(6553500, int'(MEASURE_MAX), 2, 5, 3, 2);
        @(negedge clk);
        queue_traffic(120, 2, 3);
        wait_drained();
        queue_traffic(120, 2, 3);
        wait_drained();

        // longest sample period, so no measurement; inverted window; fault blink goes on
        send_idle_pct = 20;
        stall_pct     = 20;
        load_regs(int'(MEASURE_MAX), 6553500, 65535, 40, 90, 4);
        @(negedge clk);
        queue_traffic(200, 65535, 4);
        wait_drained();
        repeat (8) @(negedge clk);

        $display("covered %0d items under %0d register writes", items_accepted, reg_writes);
        $display("with %0d measurements and %0d fault rises", measure_count, fault_rises);
        if (mismatch_count == 0)
            $display("lamp_frequency_fault_monitor_tb: done, clean");
        else
            $display("lamp_frequency_fault_monitor_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
